/* rtl/p2tc_pkg.sv */
// Shared types, codes and constants for the pixel to truecolor converter.
package p2tc_pkg;

    // Palette geometry.
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_IDX_W   = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;

    // Stream payload widths.
    localparam int SAMPLE_W   = 8;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_FMT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_FMT = 1'b1;

    typedef enum logic [1:0] {
        IN_GREY    = 2'd0,
        IN_PALETTE = 2'd1,
        IN_RGB     = 2'd2,
        IN_YCC     = 2'd3
    } t_in_fmt;

    localparam logic OUT_GREY = 1'b0;
    localparam logic OUT_RGB  = 1'b1;

    localparam logic OP_PIXEL     = 1'b0;
    localparam logic OP_PAL_WRITE = 1'b1;

    // YCbCr to RGB, 11-bit fixed point.
    localparam int   YC_COEF_W = 12;
    localparam int   YC_SUM_W  = 22;
    localparam int   YC_SHIFT  = 11;
    localparam logic [YC_COEF_W-1:0] YC_CR_R = 12'd2871;
    localparam logic [YC_COEF_W-1:0] YC_CB_G = 12'd705;
    localparam logic [YC_COEF_W-1:0] YC_CR_G = 12'd1463;
    localparam logic [YC_COEF_W-1:0] YC_CB_B = 12'd3629;
    localparam logic [SAMPLE_W:0]    YC_BIAS = 9'd128;

    // Luma weights over 10000, and the reciprocal used for the divide.
    localparam int   LUMA_COEF_W = 13;
    localparam int   LUMA_SUM_W  = 22;
    localparam logic [LUMA_COEF_W-1:0] LUMA_R = 13'd2125;
    localparam logic [LUMA_COEF_W-1:0] LUMA_G = 13'd7154;
    localparam logic [LUMA_COEF_W-1:0] LUMA_B = 13'd721;
    localparam int   DIV_SHIFT  = 36;
    localparam int   DIV_MULT_W = 23;
    // ceil(2^36 / 10000); exact for every sum below 2^22.
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = 23'd6871948;
    localparam int   DIV_PROD_W = LUMA_SUM_W + DIV_MULT_W;

    // Drop negatives to zero, shift out the fraction, saturate at 255.
    function automatic logic [SAMPLE_W-1:0] clamp_ycc(input logic signed [YC_SUM_W-1:0] v);
        logic [SAMPLE_W-1:0] res;
        if (v[YC_SUM_W-1]) begin
            res = '0;
        end else if (|v[YC_SUM_W-2:YC_SHIFT+SAMPLE_W]) begin
            res = '1;
        end else begin
            res = v[YC_SHIFT +: SAMPLE_W];
        end
        return res;
    endfunction

endpackage

/* rtl/pixel_to_truecolor_converter.sv */
// Pixel to truecolor converter: palette store, YCbCr matrix and luma pipeline.
//
//  channel   | direction | tdata (low bit up)                    | side band
//  ----------+-----------+---------------------------------------+-------------------------
//  s_axis    | in        | sample_a, sample_b, sample_c, slot    | tuser opcode, tlast eoi
//  m_axis    | out       | blue, green, red, grey                | tlast last_pixel
//  cfg       | in        | register 0 input format, 1 out format | write only, no wait
//
// One item per clock sustained while m_axis_tready keeps the output moving; a pixel
// passes palette read, YCbCr matrix, clamp and select, luma sum and reciprocal divide
// into the output register, in that order. The palette lives in a one-port-write,
// one-port-read synchronous RAM with one flip-flop valid bit per entry, so
// reset clears it at once with no clearing pass. Each stage advances when it
// is empty or the stage after it moves, so bubbles collapse and the input
// keeps taking items while a finished result waits at the output.
module pixel_to_truecolor_converter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample_a [7:0], sample_b [15:8], sample_c [23:16], palette_slot [31:24]
    input  logic [p2tc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // opcode
    input  logic                                 s_axis_tuser,
    input  logic                                 s_axis_tlast,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // blue_out [7:0], green_out [15:8], red_out [23:16], grey_out [31:24]
    output logic [p2tc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 i_cfg_we,
    input  logic [p2tc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [p2tc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int SW = p2tc_pkg::SAMPLE_W;
    localparam int YW = p2tc_pkg::YC_SUM_W;

    // ---------------- configuration ----------------
    p2tc_pkg::t_in_fmt r_in_fmt;
    logic              r_out_fmt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_fmt  <= p2tc_pkg::IN_GREY;
            r_out_fmt <= p2tc_pkg::OUT_RGB;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                p2tc_pkg::CFG_INPUT_FMT: begin
                    r_in_fmt <= p2tc_pkg::t_in_fmt'(i_cfg_data[1:0]);
                end
                p2tc_pkg::CFG_OUTPUT_FMT: begin
                    r_out_fmt <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- stage enables ----------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    assign en5 = !r_v5 || m_axis_tready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign s_axis_tready = en1;

    // ---------------- input unpack ----------------
    logic [SW-1:0] in_a, in_b, in_c, in_slot;
    logic          in_acc, pal_we, rd_ok, wr_ok;
    logic [p2tc_pkg::PAL_IDX_W-1:0] rd_idx, wr_idx;

    assign in_a    = s_axis_tdata[0*SW +: SW];
    assign in_b    = s_axis_tdata[1*SW +: SW];
    assign in_c    = s_axis_tdata[2*SW +: SW];
    assign in_slot = s_axis_tdata[3*SW +: SW];
    assign in_acc  = s_axis_tvalid && en1;
    assign rd_ok   = ({1'b0, in_a} < (SW+1)'(p2tc_pkg::PAL_ENTRIES));
    assign wr_ok   = ({1'b0, in_slot} < (SW+1)'(p2tc_pkg::PAL_ENTRIES));
    assign rd_idx  = in_a[p2tc_pkg::PAL_IDX_W-1:0];
    assign wr_idx  = in_slot[p2tc_pkg::PAL_IDX_W-1:0];
    // Writes to slots outside the palette are dropped.
    assign pal_we  = in_acc && (s_axis_tuser == p2tc_pkg::OP_PAL_WRITE) && wr_ok;

    // ---------------- palette store ----------------
    logic [3*SW-1:0]                    r_pal_mem [p2tc_pkg::PAL_ENTRIES];
    logic [p2tc_pkg::PAL_ENTRIES-1:0]   r_pal_vld;

    // Stage 1 registers
    logic [3*SW-1:0] r_s1_pal;
    logic            r_s1_pvld, r_s1_ok, r_s1_last;
    logic [SW-1:0]   r_s1_a, r_s1_b, r_s1_c;

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_pal_mem[wr_idx] <= {in_a, in_b, in_c};
        end
        if (en1) begin
            r_s1_pal <= r_pal_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_vld <= '0;
        end else if (pal_we) begin
            r_pal_vld[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= in_acc && (s_axis_tuser == p2tc_pkg::OP_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_pvld <= r_pal_vld[rd_idx];
            r_s1_ok   <= rd_ok;
            r_s1_a    <= in_a;
            r_s1_b    <= in_b;
            r_s1_c    <= in_c;
            r_s1_last <= s_axis_tlast;
        end
    end

    // ---------------- stage 2: YCbCr products, direct channels ----------------
    logic signed [SW:0]   cb, cr;
    logic signed [YW-1:0] y_fix, p_rr, p_gb, p_gr, p_bb;
    logic signed [YW-1:0] n_s2_yr, n_s2_yg, n_s2_yb;
    logic [SW-1:0]        n_s2_r, n_s2_g, n_s2_b;

    assign cb    = $signed({1'b0, r_s1_b} - p2tc_pkg::YC_BIAS);
    assign cr    = $signed({1'b0, r_s1_c} - p2tc_pkg::YC_BIAS);
    assign y_fix = $signed({{(YW-SW-p2tc_pkg::YC_SHIFT){1'b0}}, r_s1_a,
                            {p2tc_pkg::YC_SHIFT{1'b0}}});
    assign p_rr  = YW'($signed({1'b0, p2tc_pkg::YC_CR_R})) * YW'(cr);
    assign p_gb  = YW'($signed({1'b0, p2tc_pkg::YC_CB_G})) * YW'(cb);
    assign p_gr  = YW'($signed({1'b0, p2tc_pkg::YC_CR_G})) * YW'(cr);
    assign p_bb  = YW'($signed({1'b0, p2tc_pkg::YC_CB_B})) * YW'(cb);
    assign n_s2_yr = y_fix + p_rr;
    assign n_s2_yg = y_fix - p_gb - p_gr;
    assign n_s2_yb = y_fix + p_bb;

    always_comb begin
        n_s2_r = '0;
        n_s2_g = '0;
        n_s2_b = '0;
        unique case (r_in_fmt)
            p2tc_pkg::IN_GREY: begin
                n_s2_r = r_s1_a;
                n_s2_g = r_s1_a;
                n_s2_b = r_s1_a;
            end
            p2tc_pkg::IN_PALETTE: begin
                // Out-of-range index or never-written entry reads black.
                if (r_s1_ok && r_s1_pvld) begin
                    n_s2_r = r_s1_pal[2*SW +: SW];
                    n_s2_g = r_s1_pal[1*SW +: SW];
                    n_s2_b = r_s1_pal[0*SW +: SW];
                end
            end
            p2tc_pkg::IN_RGB: begin
                n_s2_r = r_s1_a;
                n_s2_g = r_s1_b;
                n_s2_b = r_s1_c;
            end
            p2tc_pkg::IN_YCC: begin
            end
            default: begin
            end
        endcase
    end

    logic signed [YW-1:0] r_s2_yr, r_s2_yg, r_s2_yb;
    logic [SW-1:0]        r_s2_r, r_s2_g, r_s2_b;
    logic                 r_s2_ycc, r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_yr   <= n_s2_yr;
            r_s2_yg   <= n_s2_yg;
            r_s2_yb   <= n_s2_yb;
            r_s2_r    <= n_s2_r;
            r_s2_g    <= n_s2_g;
            r_s2_b    <= n_s2_b;
            r_s2_ycc  <= (r_in_fmt == p2tc_pkg::IN_YCC);
            r_s2_last <= r_s1_last;
        end
    end

    // ---------------- stage 3: clamp and select ----------------
    logic [SW-1:0] r_s3_r, r_s3_g, r_s3_b;
    logic          r_s3_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_r    <= r_s2_ycc ? p2tc_pkg::clamp_ycc(r_s2_yr) : r_s2_r;
            r_s3_g    <= r_s2_ycc ? p2tc_pkg::clamp_ycc(r_s2_yg) : r_s2_g;
            r_s3_b    <= r_s2_ycc ? p2tc_pkg::clamp_ycc(r_s2_yb) : r_s2_b;
            r_s3_last <= r_s2_last;
        end
    end

    // ---------------- stage 4: weighted luma sum ----------------
    logic [p2tc_pkg::LUMA_SUM_W-1:0] n_s4_sum, r_s4_sum;
    logic [SW-1:0]                   r_s4_r, r_s4_g, r_s4_b;
    logic                            r_s4_last;

    assign n_s4_sum = p2tc_pkg::LUMA_SUM_W'(p2tc_pkg::LUMA_R) * p2tc_pkg::LUMA_SUM_W'(r_s3_r)
                    + p2tc_pkg::LUMA_SUM_W'(p2tc_pkg::LUMA_G) * p2tc_pkg::LUMA_SUM_W'(r_s3_g)
                    + p2tc_pkg::LUMA_SUM_W'(p2tc_pkg::LUMA_B) * p2tc_pkg::LUMA_SUM_W'(r_s3_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_sum  <= n_s4_sum;
            r_s4_r    <= r_s3_r;
            r_s4_g    <= r_s3_g;
            r_s4_b    <= r_s3_b;
            r_s4_last <= r_s3_last;
        end
    end

    // ---------------- stage 5: divide by 10000, output register ----------------
    logic [p2tc_pkg::DIV_PROD_W-1:0] div_prod;
    logic [SW-1:0]                   grey;
    logic [p2tc_pkg::OUT_DATA_W-1:0] n_out_data, r_out_data;
    logic                            r_out_last;

    assign div_prod = p2tc_pkg::DIV_PROD_W'(r_s4_sum) * p2tc_pkg::DIV_PROD_W'(p2tc_pkg::DIV_MULT);
    assign grey     = div_prod[p2tc_pkg::DIV_SHIFT +: SW];

    always_comb begin
        if (r_out_fmt == p2tc_pkg::OUT_RGB) begin
            n_out_data = {{SW{1'b0}}, r_s4_r, r_s4_g, r_s4_b};
        end else begin
            n_out_data = {grey, {(3*SW){1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en5) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_out_data <= n_out_data;
            r_out_last <= r_s4_last;
        end
    end

    assign m_axis_tvalid = r_v5;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    // A palette write never enters the pixel pipeline.
    a_pal_write_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == p2tc_pkg::OP_PAL_WRITE))
        |=> !r_v1)
        else $error("palette write produced a pixel in stage 1");

    // Input back-pressure only when every stage holds an item.
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5))
        else $error("input stalled with a bubble in the pipeline");

    // A palette write marks its entry valid.
    a_pal_valid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pal_we |=> r_pal_vld[$past(wr_idx)])
        else $error("palette entry not marked valid after write");

    // RGB mode never shows grey, grey mode never shows colour.
    a_out_mode_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((r_out_fmt == p2tc_pkg::OUT_RGB) ? (m_axis_tdata[3*SW +: SW] == '0)
                                              : (m_axis_tdata[3*SW-1:0] == '0)))
        else $error("output carries bytes of the wrong mode");
`endif

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the pixel to truecolor converter: directed probes and random phases.
module testbench;

    // Run control: drain margin before a register write (five-stage pipe plus slack),
    // tail wait at the end, and the cycle count without any handshake that ends the run.
    localparam int DRAIN_CYCLES = 10;
    localparam int TAIL_CYCLES  = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 88;
    localparam int NUM_PROBES   = 24;

    // Conversion constants: JFIF matrix over 2^11, Rec.709 luma weights over 10000.
    localparam int CR_TO_RED   = 2871;
    localparam int CB_TO_GREEN = 705;
    localparam int CR_TO_GREEN = 1463;
    localparam int CB_TO_BLUE  = 3629;
    localparam int CHROMA_MID  = 128;
    localparam int FRAC_BITS   = 11;
    localparam int W_RED       = 2125;
    localparam int W_GREEN     = 7154;
    localparam int W_BLUE      = 721;
    localparam int W_TOTAL     = 10000;

    typedef struct packed {
        logic       op;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] slot;
        logic       eoi;
    } t_pixel_item;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] grey;
        logic       last;
    } t_pixel_out;

    // One directed probe: formats to run it under, the item, and where the answer is
    // obvious, the typed result (known = 1); otherwise the predictor decides.
    typedef struct packed {
        p2tc_pkg::t_in_fmt in_fmt;
        logic       out_fmt;
        logic       op;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] slot;
        logic       eoi;
        logic       known;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] grey;
    } t_probe_row;

    localparam t_probe_row PROBES [NUM_PROBES] = '{
        // grey source straight after reset, then the grey byte output
        '{p2tc_pkg::IN_GREY, p2tc_pkg::OUT_RGB, p2tc_pkg::OP_PIXEL,
          8'd0, 8'hA5, 8'h5A, 8'hFF, 1'b0,
          1'b1, 8'd0, 8'd0, 8'd0, 8'd0},
        '{p2tc_pkg::IN_GREY, p2tc_pkg::OUT_RGB, p2tc_pkg::OP_PIXEL,
          8'd255, 8'd0, 8'd0, 8'd0, 1'b1,
          1'b1, 8'd255, 8'd255, 8'd255, 8'd0},
        '{p2tc_pkg::IN_GREY, p2tc_pkg::OUT_GREY, p2tc_pkg::OP_PIXEL,
          8'd255, 8'h0F, 8'hF0, 8'd0, 1'b0,
          1'b1, 8'd0, 8'd0, 8'd0, 8'd255},
        '{p2tc_pkg::IN_GREY, p2tc_pkg::OUT_GREY, p2tc_pkg::OP_PIXEL,
          8'd0, 8'd255, 8'd255, 8'd255, 1'b1,
          1'b1, 8'd0, 8'd0, 8'd0, 8'd0},
        // unwritten palette entry reads black
        '{p2tc_pkg::IN_PALETTE, p2tc_pkg::OUT_RGB, p2tc_pkg::OP_PIXEL,
          8'd7, 8'd0, 8'd0, 8'd0, 1'b0,
          1'b1, 8'd0, 8'd0, 8'd0, 8'd0},
        // palette loads at both ends and in the middle
        '{p2tc_pkg::IN_PALETTE, p2tc_pkg::OUT_RGB, p2tc_pkg::OP_PAL_WRITE,
          8'd255, 8'd255, 8'd255, 8'd0, 1'b1,
          1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{p2tc_pkg::IN_PALETTE, p2tc_pkg::OUT_RGB, p2tc_pkg::OP_PAL_WRITE,
          8'd1, 8'd2, 8'd3, 8'd255, 1'b0,
          1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{p2tc_pkg::IN_PALETTE, p2tc_pkg::OUT_RGB, p2tc_pkg::OP_PAL_WRITE,
          8'h12, 8'h34, 8'h56, 8'd7, 1'b0,
          1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{p2tc_pkg::IN_PALETTE, p2tc_pkg::OUT_RGB, p2tc_pkg::OP_PIXEL,
          8'd0, 8'd255, 8'd255, 8'hC3, 1'b0,
          1'b1, 8'd255, 8'd255, 8'd255, 8'd0},
        '{p2tc_pkg::IN_PALETTE, p2tc_pkg::OUT_RGB, p2tc_pkg::OP_PIXEL,
          8'd255, 8'd0, 8'd0, 8'd0, 1'b1,
          1'b1, 8'd3, 8'd2, 8'd1, 8'd0},
        '{p2tc_pkg::IN_PALETTE, p2tc_pkg::OUT_RGB, p2tc_pkg::OP_PIXEL,
          8'd7, 8'd9, 8'd9, 8'd9, 1'b0,
          1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{p2tc_pkg::IN_PALETTE, p2tc_pkg::OUT_GREY, p2tc_pkg::OP_PIXEL,
          8'd0, 8'd0, 8'd0, 8'd0, 1'b0,
          1'b1, 8'd0, 8'd0, 8'd0, 8'd255},
        '{p2tc_pkg::IN_PALETTE, p2tc_pkg::OUT_GREY, p2tc_pkg::OP_PIXEL,
          8'd7, 8'd0, 8'd0, 8'd0, 1'b1,
          1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
        // planar rgb: channel order, then each luma weight on its own
        '{p2tc_pkg::IN_RGB, p2tc_pkg::OUT_RGB, p2tc_pkg::OP_PIXEL,
          8'd255, 8'd0, 8'd0, 8'd0, 1'b0,
          1'b1, 8'd0, 8'd0, 8'd255, 8'd0},
        '{p2tc_pkg::IN_RGB, p2tc_pkg::OUT_RGB, p2tc_pkg::OP_PIXEL,
          8'd0, 8'd0, 8'd255, 8'd255, 1'b1,
          1'b1, 8'd255, 8'd0, 8'd0, 8'd0},
        '{p2tc_pkg::IN_RGB, p2tc_pkg::OUT_GREY, p2tc_pkg::OP_PIXEL,
          8'd255, 8'd0, 8'd0, 8'd0, 1'b0,
          1'b1, 8'd0, 8'd0, 8'd0, 8'd54},
        '{p2tc_pkg::IN_RGB, p2tc_pkg::OUT_GREY, p2tc_pkg::OP_PIXEL,
          8'd0, 8'd0, 8'd255, 8'd0, 1'b0,
          1'b1, 8'd0, 8'd0, 8'd0, 8'd18},
        '{p2tc_pkg::IN_RGB, p2tc_pkg::OUT_GREY, p2tc_pkg::OP_PIXEL,
          8'd0, 8'd255, 8'd0, 8'd0, 1'b0,
          1'b1, 8'd0, 8'd0, 8'd0, 8'd182},
        '{p2tc_pkg::IN_RGB, p2tc_pkg::OUT_GREY, p2tc_pkg::OP_PIXEL,
          8'd255, 8'd255, 8'd255, 8'd0, 1'b1,
          1'b1, 8'd0, 8'd0, 8'd0, 8'd255},
        // ycbcr: neutral chroma, then both clamps
        '{p2tc_pkg::IN_YCC, p2tc_pkg::OUT_RGB, p2tc_pkg::OP_PIXEL,
          8'd128, 8'd128, 8'd128, 8'd0, 1'b0,
          1'b1, 8'd128, 8'd128, 8'd128, 8'd0},
        '{p2tc_pkg::IN_YCC, p2tc_pkg::OUT_RGB, p2tc_pkg::OP_PIXEL,
          8'd255, 8'd255, 8'd255, 8'd0, 1'b0,
          1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{p2tc_pkg::IN_YCC, p2tc_pkg::OUT_RGB, p2tc_pkg::OP_PIXEL,
          8'd0, 8'd0, 8'd0, 8'd255, 1'b1,
          1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{p2tc_pkg::IN_YCC, p2tc_pkg::OUT_GREY, p2tc_pkg::OP_PIXEL,
          8'd255, 8'd128, 8'd128, 8'd0, 1'b0,
          1'b1, 8'd0, 8'd0, 8'd0, 8'd255},
        '{p2tc_pkg::IN_YCC, p2tc_pkg::OUT_GREY, p2tc_pkg::OP_PIXEL,
          8'd0, 8'd255, 8'd0, 8'd0, 1'b1,
          1'b0, 8'd0, 8'd0, 8'd0, 8'd0}
    };

    logic                                i_clk;
    logic                                i_rst_n;
    logic [p2tc_pkg::IN_DATA_W-1:0]      s_axis_tdata;
    logic                                s_axis_tuser;
    logic                                s_axis_tlast;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [p2tc_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
    logic                                m_axis_tlast;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic                                i_cfg_we;
    logic [p2tc_pkg::CFG_IDX_W-1:0]      i_cfg_idx;
    logic [p2tc_pkg::CFG_DATA_W-1:0]     i_cfg_data;

    // Predictor state: its own copy of the registers and the palette.
    p2tc_pkg::t_in_fmt cur_in_fmt;
    logic        cur_out_fmt;
    logic [23:0] shadow_palette [p2tc_pkg::PAL_ENTRIES];

    t_pixel_out  pending_pixels [$];
    int          mismatches;
    int          stall_cycles;
    bit          calm_run;

    pixel_to_truecolor_converter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drop negatives, shift out the fraction, saturate at 255.
    function automatic logic [7:0] sat_byte(input int v);
        int q;
        if (v < 0) begin
            return 8'd0;
        end
        q = v >>> FRAC_BITS;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Expected result of one convert item under the current register settings.
    function automatic t_pixel_out convert_pixel(input t_pixel_item it);
        t_pixel_out  res;
        logic [23:0] entry;
        int          r;
        int          g;
        int          bl;
        int          y;
        int          cb;
        int          cr;
        res      = '0;
        res.last = it.eoi;
        case (cur_in_fmt)
            p2tc_pkg::IN_GREY: begin
                r  = it.a;
                g  = it.a;
                bl = it.a;
            end
            p2tc_pkg::IN_PALETTE: begin
                // An index past the palette reads black.
                entry = (it.a < p2tc_pkg::PAL_ENTRIES) ? shadow_palette[it.a] : 24'd0;
                r     = entry[23:16];
                g     = entry[15:8];
                bl    = entry[7:0];
            end
            p2tc_pkg::IN_RGB: begin
                r  = it.a;
                g  = it.b;
                bl = it.c;
            end
            default: begin
                y  = it.a;
                y  = y << FRAC_BITS;
                cb = it.b;
                cb = cb - CHROMA_MID;
                cr = it.c;
                cr = cr - CHROMA_MID;
                r  = sat_byte(y + CR_TO_RED * cr);
                g  = sat_byte(y - CB_TO_GREEN * cb - CR_TO_GREEN * cr);
                bl = sat_byte(y + CB_TO_BLUE * cb);
            end
        endcase
        if (cur_out_fmt == p2tc_pkg::OUT_GREY) begin
            if (cur_in_fmt == p2tc_pkg::IN_GREY) begin
                res.grey = it.a;
            end else begin
                y        = (W_RED * r + W_GREEN * g + W_BLUE * bl) / W_TOTAL;
                res.grey = y[7:0];
            end
        end else begin
            res.blue  = bl[7:0];
            res.green = g[7:0];
            res.red   = r[7:0];
        end
        return res;
    endfunction

    // Extremes one time in four, anything otherwise.
    function automatic logic [7:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Palette traffic leans on the low 16 slots so that lookups mostly hit loaded entries.
    function automatic logic [7:0] rand_slot();
        return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 15)) : rand_sample();
    endfunction

    function automatic t_pixel_item random_item(input p2tc_pkg::t_in_fmt fmt);
        t_pixel_item it;
        int          write_pct;
        write_pct = (fmt == p2tc_pkg::IN_PALETTE) ? 30 : 10;
        it.op     = ($urandom_range(0, 99) < write_pct) ? p2tc_pkg::OP_PAL_WRITE
                                                        : p2tc_pkg::OP_PIXEL;
        it.a      = (fmt == p2tc_pkg::IN_PALETTE && it.op == p2tc_pkg::OP_PIXEL)
                    ? rand_slot() : rand_sample();
        it.b      = rand_sample();
        it.c      = rand_sample();
        it.slot   = (it.op == p2tc_pkg::OP_PAL_WRITE) ? rand_slot() : rand_sample();
        it.eoi    = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    // Present one item after a random gap and hold it until taken. On acceptance,
    // load the palette copy or queue the expected pixel (typed or predicted).
    task automatic push_item(input t_pixel_item it, input bit typed, input t_pixel_out want);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            calm_run = !calm_run;
        end
        gap = calm_run ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.slot, it.c, it.b, it.a};
        s_axis_tuser  <= it.op;
        s_axis_tlast  <= it.eoi;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        if (it.op == p2tc_pkg::OP_PAL_WRITE) begin
            // Drop writes past the palette.
            if (it.slot < p2tc_pkg::PAL_ENTRIES) begin
                shadow_palette[it.slot] = {it.a, it.b, it.c};
            end
        end else if (typed) begin
            pending_pixels.push_back(want);
        end else begin
            pending_pixels.push_back(convert_pixel(it));
        end
    endtask

    // Let the pipe run dry, then write both registers. Palette loads give no result,
    // so hold for the drain margin past the last pixel before touching the registers.
    task automatic set_formats(input p2tc_pkg::t_in_fmt fin, input logic fout);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= p2tc_pkg::CFG_INPUT_FMT;
        i_cfg_data <= fin;
        @(negedge i_clk);
        // the upper data bit is don't-care for the one-bit register; randomise it anyway
        i_cfg_idx  <= p2tc_pkg::CFG_OUTPUT_FMT;
        i_cfg_data <= {1'($urandom_range(0, 1)), fout};
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_in_fmt  = fin;
        cur_out_fmt = fout;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Result side: random back-pressure per item, compare in order on acceptance.
    initial begin
        t_pixel_out want;
        int         gap;
        m_axis_tready = 1'b0;
        while (!i_rst_n) begin
            @(negedge i_clk);
        end
        forever begin
            gap = calm_run ? 0 : $urandom_range(0, 9);
            @(negedge i_clk);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) begin
                @(posedge i_clk);
            end
            if (pending_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected pixel, expected none, got %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
            end else begin
                want = pending_pixels.pop_front();
                check_field("blue_out", want.blue, m_axis_tdata[7:0]);
                check_field("green_out", want.green, m_axis_tdata[15:8]);
                check_field("red_out", want.red, m_axis_tdata[23:16]);
                check_field("grey_out", want.grey, m_axis_tdata[31:24]);
                check_field("last_pixel", {7'd0, want.last}, {7'd0, m_axis_tlast});
            end
        end
    end

    // Watchdog: end the run if neither side hands over an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Main sequence: reset, directed probes, random phases over every format pair.
    initial begin
        t_probe_row        row;
        t_pixel_item       it;
        p2tc_pkg::t_in_fmt fin;
        logic              fout;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = p2tc_pkg::OP_PIXEL;
        s_axis_tlast  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = p2tc_pkg::CFG_INPUT_FMT;
        i_cfg_data    = '0;
        calm_run      = 1'b0;
        cur_in_fmt    = p2tc_pkg::IN_GREY;
        cur_out_fmt   = p2tc_pkg::OUT_RGB;
        foreach (shadow_palette[i]) begin
            shadow_palette[i] = '0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed probes: switch formats only when a row asks for a different pair,
        // so the first rows run under the reset settings.
        for (int n = 0; n < NUM_PROBES; n++) begin
            row = PROBES[n];
            if (row.in_fmt != cur_in_fmt || row.out_fmt != cur_out_fmt) begin
                set_formats(row.in_fmt, row.out_fmt);
            end
            it = '{row.op, row.a, row.b, row.c, row.slot, row.eoi};
            push_item(it, row.known, '{row.blue, row.green, row.red, row.grey, row.eoi});
        end

        // Random phases: the first eight sweep every format pair, the rest pick at random.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 8) begin
                fin  = p2tc_pkg::t_in_fmt'(p % 4);
                fout = (p >= 4) ? p2tc_pkg::OUT_RGB : p2tc_pkg::OUT_GREY;
            end else begin
                fin  = p2tc_pkg::t_in_fmt'($urandom_range(0, 3));
                fout = 1'($urandom_range(0, 1));
            end
            set_formats(fin, fout);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                push_item(random_item(fin), 1'b0, '0);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/p2tc_pkg.sv
rtl/pixel_to_truecolor_converter.sv
sim/testbench.sv
